### design/gcr_six_and_two_sector_decoder_defines.svh
// Assertion macros used by the 6-and-2 sector decoder top level.
`ifndef GCR_SIX_AND_TWO_SECTOR_DECODER_DEFINES_SVH
`define GCR_SIX_AND_TWO_SECTOR_DECODER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on clock and disabled during reset.
`define GCR62_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("gcr62: same-cycle check failed");

// Next-cycle implication, sampled on clock and disabled during reset.
`define GCR62_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("gcr62: next-cycle check failed");

`else

`define GCR62_ASSERT_IMPL(label, ante, cons)
`define GCR62_ASSERT_NEXT(label, ante, cons)

`endif

`endif

### design/gcr62_pkg.sv
// Constants, types and the reverse translation table of the 6-and-2 sector decoder.
package gcr62_pkg;

   // Sector data field layout.
   localparam int FRAGMENT_SPAN = 86;
   localparam int DATA_BYTES    = 256;
   localparam int COUNT_W       = 9;
   localparam int FRAG_ADDR_W   = $clog2(FRAGMENT_SPAN);
   localparam int CODE_W        = 6;
   localparam int BYTE_W        = 8;
   localparam int INDEX_W       = 8;

   localparam logic [COUNT_W-1:0] SPAN_POS   = COUNT_W'(FRAGMENT_SPAN);
   localparam logic [COUNT_W-1:0] CHECK_POS  = COUNT_W'(FRAGMENT_SPAN + DATA_BYTES);
   localparam logic [COUNT_W-1:0] IDLE_POS   = COUNT_W'(FRAGMENT_SPAN + DATA_BYTES + 1);
   localparam logic [INDEX_W-1:0] SPAN_IDX   = INDEX_W'(FRAGMENT_SPAN);
   localparam logic [INDEX_W-1:0] SPAN2_IDX  = INDEX_W'(2 * FRAGMENT_SPAN);
   localparam logic [INDEX_W-1:0] LAST_IDX   = INDEX_W'(DATA_BYTES - 1);

   // What a nibble at a given field position does.
   typedef enum logic [2:0] {
      KIND_FRAG,
      KIND_GROUP0,
      KIND_GROUP1,
      KIND_GROUP2,
      KIND_CHECK
   } item_kind_type;

   // The 64 valid disk bytes, in code order.
   localparam logic [7:0] GCR_WRITE_ROM [0:63] = '{
      8'h96, 8'h97, 8'h9A, 8'h9B, 8'h9D, 8'h9E, 8'h9F, 8'hA6,
      8'hA7, 8'hAB, 8'hAC, 8'hAD, 8'hAE, 8'hAF, 8'hB2, 8'hB3,
      8'hB4, 8'hB5, 8'hB6, 8'hB7, 8'hB9, 8'hBA, 8'hBB, 8'hBC,
      8'hBD, 8'hBE, 8'hBF, 8'hCB, 8'hCD, 8'hCE, 8'hCF, 8'hD3,
      8'hD6, 8'hD7, 8'hD9, 8'hDA, 8'hDB, 8'hDC, 8'hDD, 8'hDE,
      8'hDF, 8'hE5, 8'hE6, 8'hE7, 8'hE9, 8'hEA, 8'hEB, 8'hEC,
      8'hED, 8'hEE, 8'hEF, 8'hF2, 8'hF3, 8'hF4, 8'hF5, 8'hF6,
      8'hF7, 8'hF9, 8'hFA, 8'hFB, 8'hFC, 8'hFD, 8'hFE, 8'hFF
   };

   typedef logic [CODE_W-1:0] gcr_rev_table_type [0:127];

   // Builds the reverse table on the low seven bits; unused entries map to zero.
   function automatic gcr_rev_table_type build_rev_table();
      gcr_rev_table_type t;
      for (int i = 0; i < 128; i++) begin
         t[i] = '0;
      end
      for (int k = 0; k < 64; k++) begin
         t[GCR_WRITE_ROM[k][6:0]] = CODE_W'(k);
      end
      return t;
   endfunction

   localparam gcr_rev_table_type GCR_REV_TABLE = build_rev_table();

endpackage

### design/gcr62_req_if.sv
// Handshake channels of the 6-and-2 sector decoder: nibble input and byte output.
interface gcr62_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] nibble;
   logic       sector_start;

   modport source (output valid, output nibble, output sector_start, input ready);
   modport sink   (input valid, input nibble, input sector_start, output ready);
endinterface

interface gcr62_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic [7:0] byte_index;
   logic       last;

   modport source (output valid, output data_byte, output byte_index, output last,
                   input ready);
   modport sink   (input valid, input data_byte, input byte_index, input last,
                   output ready);
endinterface

### design/gcr62_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module gcr62_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port; read data holds when no read is issued.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/gcr_six_and_two_sector_decoder.sv
// Top level of the 6-and-2 GCR sector data decoder.
//
//   channel   direction  handshake             word
//   req_port  in         valid/ready           nibble[7:0], sector_start
//   rsp_port  out        valid/ready           data_byte[7:0], byte_index[7:0], last
//
// One nibble is accepted per cycle unless req_port.ready is low; the second stage
// and then the output register hold its byte. The fragment RAM read is issued on
// accept, so its registered read data meets the chained value in the second stage.
// Synchronous reset clears the nibble count, the chain value and all valid flags;
// the fragment RAM is not cleared.
// A stalled output holds the second stage, which in turn drops req_port.ready.
`include "gcr_six_and_two_sector_decoder_defines.svh"

module gcr_six_and_two_sector_decoder
   import gcr62_pkg::*;
(
   input logic         clock,
   input logic         reset,
   gcr62_req_if.sink   req_port,
   gcr62_rsp_if.source rsp_port
);

   // Field position and chain state.
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic [CODE_W-1:0]      chain_ff, chain_in;

   // Second stage registers.
   logic                   s1_valid_ff, s1_valid_in;
   logic [CODE_W-1:0]      s1_code_ff;
   logic                   s1_start_ff;
   item_kind_type          s1_kind_ff;
   logic [INDEX_W-1:0]     s1_idx_ff;
   logic [FRAG_ADDR_W-1:0] s1_waddr_ff;

   // Output register.
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]      rsp_byte_ff;
   logic [INDEX_W-1:0]     rsp_index_ff;
   logic                   rsp_last_ff;

   logic                   out_free;
   logic                   s1_go;
   logic                   accept;
   logic [COUNT_W-1:0]     pos;
   logic                   active;
   logic [COUNT_W-1:0]     idx_wide;
   logic [INDEX_W-1:0]     idx;
   item_kind_type          kind;
   logic [FRAG_ADDR_W-1:0] slot;
   logic                   ram_rd_en;
   logic                   ram_wr_en;
   logic [CODE_W-1:0]      pack;
   logic [CODE_W-1:0]      value;
   logic [1:0]             low_bits;
   logic                   s1_has_byte;

   // Flow control: the output register frees when empty or taken.
   assign out_free       = !rsp_valid_ff || rsp_port.ready;
   assign s1_go          = s1_valid_ff && out_free;
   assign req_port.ready = !s1_valid_ff || out_free;
   assign accept         = req_port.valid && req_port.ready;

   // Position of the incoming nibble within the data field.
   always_comb begin
      pos      = req_port.sector_start ? '0 : count_ff;
      active   = pos < IDLE_POS;
      idx_wide = pos - SPAN_POS;
      idx      = idx_wide[INDEX_W-1:0];
      if (pos < SPAN_POS) begin
         kind = KIND_FRAG;
      end else if (pos >= CHECK_POS) begin
         kind = KIND_CHECK;
      end else if (idx < SPAN_IDX) begin
         kind = KIND_GROUP0;
      end else if (idx < SPAN2_IDX) begin
         kind = KIND_GROUP1;
      end else begin
         kind = KIND_GROUP2;
      end
   end

   // Fragment pack slot for a data byte.
   always_comb begin
      unique case (kind)
         KIND_GROUP1: slot = FRAG_ADDR_W'(idx - SPAN_IDX);
         KIND_GROUP2: slot = FRAG_ADDR_W'(idx - SPAN2_IDX);
         default:     slot = idx[FRAG_ADDR_W-1:0];
      endcase
   end

   assign ram_rd_en = accept && active &&
                      (kind == KIND_GROUP0 || kind == KIND_GROUP1 || kind == KIND_GROUP2);

   // Count holds past the checksum until the next start mark.
   always_comb begin
      count_in = count_ff;
      if (accept) begin
         count_in = active ? pos + 1'b1 : pos;
      end
   end

   // Second stage: chain the translated code with the running value.
   assign value     = (s1_start_ff ? '0 : chain_ff) ^ s1_code_ff;
   assign ram_wr_en = s1_go && (s1_kind_ff == KIND_FRAG);
   assign chain_in  = s1_go ? value : chain_ff;

   // Pick the two swapped low bits from the stored pack.
   always_comb begin
      unique case (s1_kind_ff)
         KIND_GROUP1: low_bits = {pack[2], pack[3]};
         KIND_GROUP2: low_bits = {pack[4], pack[5]};
         default:     low_bits = {pack[0], pack[1]};
      endcase
   end

   assign s1_has_byte = (s1_kind_ff == KIND_GROUP0) || (s1_kind_ff == KIND_GROUP1) ||
                        (s1_kind_ff == KIND_GROUP2);

   // Stage and output valid flags.
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_port.ready) begin
         s1_valid_in = accept && active;
      end
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = s1_valid_ff && s1_has_byte;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         chain_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         chain_ff     <= chain_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_code_ff  <= GCR_REV_TABLE[req_port.nibble[6:0]];
         s1_start_ff <= req_port.sector_start;
         s1_kind_ff  <= kind;
         s1_idx_ff   <= idx;
         s1_waddr_ff <= pos[FRAG_ADDR_W-1:0];
      end
      if (s1_go) begin
         rsp_byte_ff  <= {value, low_bits};
         rsp_index_ff <= s1_idx_ff;
         rsp_last_ff  <= (s1_idx_ff == LAST_IDX);
      end
   end

   // Fragment pack store.
   gcr62_ram #(
      .WIDTH (CODE_W),
      .DEPTH (FRAGMENT_SPAN)
   ) u_frag_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (s1_waddr_ff),
      .wr_data (value),
      .rd_en   (ram_rd_en),
      .rd_addr (slot),
      .rd_data (pack)
   );

   assign rsp_port.valid      = rsp_valid_ff;
   assign rsp_port.data_byte  = rsp_byte_ff;
   assign rsp_port.byte_index = rsp_index_ff;
   assign rsp_port.last       = rsp_last_ff;

   // The count never runs past the idle position.
   `GCR62_ASSERT_IMPL(a_count_bound, 1'b1, count_ff <= IDLE_POS)
   // A last word always carries the final byte index.
   `GCR62_ASSERT_IMPL(a_last_index, rsp_valid_ff && rsp_last_ff, rsp_index_ff == LAST_IDX)
   // A pack is never read in the cycle that writes it.
   `GCR62_ASSERT_IMPL(a_ram_no_collide, ram_wr_en && ram_rd_en, s1_waddr_ff != slot)
   // A stalled second stage keeps its item.
   `GCR62_ASSERT_NEXT(a_s1_hold, s1_valid_ff && !out_free, s1_valid_ff)

endmodule

### tb/gcr_six_and_two_sector_decoder_tb.sv
// Self-checking testbench for the 6-and-2 GCR sector data decoder.
`timescale 1ns / 1ps

import gcr62_pkg::*;

// The 64 valid disk bytes in code order, used both to predict and to build nibbles.
localparam logic [7:0] DISK_CODES [0:63] = '{
   8'h96, 8'h97, 8'h9A, 8'h9B, 8'h9D, 8'h9E, 8'h9F, 8'hA6,
   8'hA7, 8'hAB, 8'hAC, 8'hAD, 8'hAE, 8'hAF, 8'hB2, 8'hB3,
   8'hB4, 8'hB5, 8'hB6, 8'hB7, 8'hB9, 8'hBA, 8'hBB, 8'hBC,
   8'hBD, 8'hBE, 8'hBF, 8'hCB, 8'hCD, 8'hCE, 8'hCF, 8'hD3,
   8'hD6, 8'hD7, 8'hD9, 8'hDA, 8'hDB, 8'hDC, 8'hDD, 8'hDE,
   8'hDF, 8'hE5, 8'hE6, 8'hE7, 8'hE9, 8'hEA, 8'hEB, 8'hEC,
   8'hED, 8'hEE, 8'hEF, 8'hF2, 8'hF3, 8'hF4, 8'hF5, 8'hF6,
   8'hF7, 8'hF9, 8'hFA, 8'hFB, 8'hFC, 8'hFD, 8'hFE, 8'hFF
};

localparam int FIELD_LEN = FRAGMENT_SPAN + DATA_BYTES + 1;

typedef struct packed {
   logic [7:0] data_byte;
   logic [7:0] byte_index;
   logic       last;
} sector_byte_type;

// Tracks the decoder state from accepted nibbles and checks each decoded byte.
class sector_byte_board;
   logic [8:0]      field_pos;
   logic [7:0]      chain;
   logic [7:0]      packs [FRAGMENT_SPAN];
   sector_byte_type expected_bytes [$];
   int              errors;
   int              nibbles_taken;
   int              ignored_seen;
   int              invalid_seen;
   int              restarts;
   int              bytes_checked;
   int              sectors_seen;

   function new();
      field_pos = '0;
      chain     = '0;
   endfunction

   function int pending();
      return expected_bytes.size();
   endfunction

   task report_mismatch(string what);
      errors++;
      $display("[%0t] mismatch: %s", $time, what);
   endtask

   // Advances the field state by one nibble and queues the byte it yields, if any.
   function void note_nibble(logic [7:0] nib, logic mark);
      logic [5:0]      code;
      logic            found;
      logic [7:0]      v;
      logic [7:0]      pack;
      logic [1:0]      low;
      int              pos;
      int              idx;
      item_kind_type   kind;
      sector_byte_type b;
      nibbles_taken++;
      if (mark) begin
         field_pos = '0;
         chain     = '0;
         restarts++;
      end
      if (field_pos >= FIELD_LEN) begin
         ignored_seen++;
         return;
      end
      // Reverse translation on the low seven bits with the top bit set; no match decodes to zero.
      code  = '0;
      found = 1'b0;
      for (int k = 0; k < 64; k++) begin
         if (DISK_CODES[k] == {1'b1, nib[6:0]}) begin
            code  = 6'(k);
            found = 1'b1;
         end
      end
      if (!found) begin
         invalid_seen++;
      end
      v         = chain ^ {code, 2'b00};
      chain     = v;
      pos       = int'(field_pos);
      field_pos = field_pos + 9'd1;
      idx       = pos - FRAGMENT_SPAN;
      if (pos < FRAGMENT_SPAN) begin
         kind = KIND_FRAG;
      end else if (pos >= FRAGMENT_SPAN + DATA_BYTES) begin
         kind = KIND_CHECK;
      end else if (idx < FRAGMENT_SPAN) begin
         kind = KIND_GROUP0;
      end else if (idx < 2 * FRAGMENT_SPAN) begin
         kind = KIND_GROUP1;
      end else begin
         kind = KIND_GROUP2;
      end
      pack = (kind == KIND_FRAG || kind == KIND_CHECK) ? 8'h00 : packs[idx % FRAGMENT_SPAN];
      // The two low bits of each fragment are stored swapped.
      case (kind)
         KIND_FRAG: begin
            packs[pos] = v;
            return;
         end
         KIND_GROUP0: low = {pack[2], pack[3]};
         KIND_GROUP1: low = {pack[4], pack[5]};
         KIND_GROUP2: low = {pack[6], pack[7]};
         default: return;
      endcase
      b.data_byte  = {v[7:2], low};
      b.byte_index = idx[7:0];
      b.last       = (idx == DATA_BYTES - 1);
      if (b.last) begin
         sectors_seen++;
      end
      expected_bytes.push_back(b);
   endfunction

   // Compares one decoded byte with the oldest expected byte.
   task check_byte(logic [7:0] data_byte, logic [7:0] byte_index, logic last);
      sector_byte_type e;
      if (expected_bytes.size() == 0) begin
         report_mismatch($sformatf("unexpected byte %h at index %0d", data_byte, byte_index));
         return;
      end
      e = expected_bytes.pop_front();
      bytes_checked++;
      if (data_byte !== e.data_byte) begin
         report_mismatch($sformatf("byte %0d: data %h, expected %h",
                                   e.byte_index, data_byte, e.data_byte));
      end
      if (byte_index !== e.byte_index) begin
         report_mismatch($sformatf("index %0d, expected %0d", byte_index, e.byte_index));
      end
      if (last !== e.last) begin
         report_mismatch($sformatf("byte %0d: last %b, expected %b",
                                   e.byte_index, last, e.last));
      end
   endtask
endclass

module gcr_six_and_two_sector_decoder_tb;

   localparam int          HALF_PERIOD  = 4;
   localparam int          ITEM_GOAL    = 1400;
   localparam int          DRAIN_CYCLES = 16;
   localparam longint      LIMIT_NS     = 4_000_000;

   typedef enum {FIELD_RANDOM, FIELD_CONSTANT, FIELD_CUT} field_kind_type;

   // Corner nibbles: zero, all ones, bit 7 clear and set, valid codes and invalid bytes.
   localparam logic [7:0] EDGE_NIBBLES [0:19] = '{
      8'h00, 8'hFF, 8'h7F, 8'h80, 8'h96, 8'h16, 8'hAA, 8'hD5, 8'h2A, 8'h55,
      8'h01, 8'hFE, 8'hE5, 8'h65, 8'h9B, 8'hC0, 8'h40, 8'hB2, 8'h33, 8'hFC
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic quiet_tail = 1'b0;
   int   gap_odds = 5;
   int   stall_left = 0;
   logic drained_once = 1'b0;

   sector_byte_board sb;

   gcr62_req_if req_ch ();
   gcr62_rsp_if rsp_ch ();

   gcr_six_and_two_sector_decoder DUT (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_ch),
      .rsp_port (rsp_ch)
   );

   // Free-running clock.
   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // Both handshakes are observed at the same edge, inputs first.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            sb.note_nibble(req_ch.nibble, req_ch.sector_start);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            sb.check_byte(rsp_ch.data_byte, rsp_ch.byte_index, rsp_ch.last);
         end
      end
   end

   // Output back-pressure in bursts of random length, off in the tail of the run.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (stall_left != 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left--;
      end else if (!quiet_tail && $urandom_range(0, 6) == 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left = $urandom_range(0, 7);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   function automatic int live_items();
      return sb.nibbles_taken - sb.ignored_seen;
   endfunction

   // Mostly valid disk bytes with a random top bit, now and then any byte at all.
   function automatic logic [7:0] rand_nibble();
      if ($urandom_range(0, 9) == 0) begin
         return 8'($urandom_range(0, 255));
      end
      return {1'($urandom_range(0, 1)), DISK_CODES[$urandom_range(0, 63)][6:0]};
   endfunction

   // Presents one word, after an optional gap, and returns once it is taken.
   task automatic send_nibble(logic [7:0] nib, logic mark);
      if (!quiet_tail && $urandom_range(0, 99) < gap_odds) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.nibble       <= nib;
      req_ch.sector_start <= mark;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   // Sends one data field, whole or cut short, plus a few surplus nibbles after a whole one.
   task automatic send_field(field_kind_type kind);
      int         len;
      logic [7:0] fill;
      len      = (kind == FIELD_CUT) ? $urandom_range(1, FIELD_LEN - 1) : FIELD_LEN;
      fill     = rand_nibble();
      gap_odds = ($urandom_range(0, 3) == 0) ? 0 : 20;
      for (int p = 0; p < len; p++) begin
         // The run stops sending once it has used up its share of words.
         if (sb.nibbles_taken >= ITEM_GOAL) begin
            break;
         end
         // Once in the run, hold the input until every pending byte has drained.
         if (!drained_once && live_items() >= 600) begin
            drained_once = 1'b1;
            req_ch.valid <= 1'b0;
            do @(negedge clock); while (sb.pending() != 0);
         end
         if (sb.nibbles_taken >= ITEM_GOAL - 250) begin
            quiet_tail = 1'b1;
         end
         send_nibble((kind == FIELD_CONSTANT) ? {1'($urandom_range(0, 1)), fill[6:0]}
                                              : rand_nibble(), p == 0);
      end
      if (kind != FIELD_CUT && sb.nibbles_taken < ITEM_GOAL) begin
         repeat ($urandom_range(0, 4)) send_nibble(rand_nibble(), 1'b0);
      end
   endtask

   initial begin
      int pick;
      req_ch.valid        = 1'b0;
      req_ch.nibble       = 8'h00;
      req_ch.sector_start = 1'b0;
      rsp_ch.ready        = 1'b0;
      sb = new();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Corner nibbles open the first field, which has no start mark after reset.
      foreach (EDGE_NIBBLES[i]) begin
         send_nibble(EDGE_NIBBLES[i], 1'b0);
      end
      // The rest of that field uses the top code, so decoded bytes reach all ones.
      for (int p = $size(EDGE_NIBBLES); p < FIELD_LEN; p++) begin
         send_nibble({1'($urandom_range(0, 1)), 7'h7F}, 1'b0);
      end
      repeat (3) send_nibble(rand_nibble(), 1'b0);
      send_field(FIELD_CONSTANT);

      // Random fields: mostly whole ones, some filled with one code, some cut short.
      while (sb.nibbles_taken < ITEM_GOAL) begin
         pick = $urandom_range(0, 9);
         send_field(pick < 6 ? FIELD_RANDOM : (pick < 8 ? FIELD_CONSTANT : FIELD_CUT));
      end
      req_ch.valid <= 1'b0;

      // Let the pipeline empty, then look for stray bytes.
      for (int w = 0; w < 4000 && sb.pending() != 0; w++) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.pending() != 0) begin
         sb.report_mismatch($sformatf("%0d expected bytes never came out", sb.pending()));
      end

      $display("Sent %0d nibbles (%0d invalid, %0d past the checksum) across %0d start marks.",
               sb.nibbles_taken, sb.invalid_seen, sb.ignored_seen, sb.restarts);
      $display("Checked %0d decoded bytes over %0d complete sectors; %0d mismatches.",
               sb.bytes_checked, sb.sectors_seen, sb.errors);
      if (sb.errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #(LIMIT_NS);
      $display("Run stopped by the watchdog.");
      $display("== FAIL ==");
      $finish;
   end

endmodule
